FILE: rtl/bpec_pkg.sv
// shared types and constants for the button press event classifier
// no dependencies; imported by bpec_dp, bpec_ctrl and the top level
package bpec_pkg;

	// default widths of the tick and count datapaths
	localparam int BPEC_TICK_BITS  = 16;
	localparam int BPEC_COUNT_BITS = 8;

	// configuration register indexes
	localparam logic [2:0] REG_ACTIVE_LEVEL  = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE      = 3'd1;
	localparam logic [2:0] REG_SHORT         = 3'd2;
	localparam logic [2:0] REG_LONG          = 3'd3;
	localparam logic [2:0] REG_LONG_REPORT   = 3'd4;
	localparam logic [2:0] REG_LAST_TIMEOUT  = 3'd5;

	// configuration reset values
	localparam logic        RST_ACTIVE_LEVEL = 1'b0;
	localparam logic [7:0]  RST_DEBOUNCE     = 8'd3;
	localparam logic [15:0] RST_SHORT        = 16'd60;
	localparam logic [15:0] RST_LONG         = 16'd200;
	localparam logic [15:0] RST_LONG_REPORT  = 16'd20;
	localparam logic [15:0] RST_LAST_TIMEOUT = 16'd100;

	typedef enum logic [2:0] {
		EVT_NONE         = 3'd0,
		EVT_DOWN         = 3'd1,
		EVT_UP           = 3'd2,
		EVT_REPEAT       = 3'd3,
		EVT_LONG_START   = 3'd4,
		EVT_LONG_HOLD    = 3'd5,
		EVT_LONG_RELEASE = 3'd6
	} bpec_evt_t;

	// gesture classifier states
	typedef enum logic [2:0] {
		GST_IDLE     = 3'd0,
		GST_PRESSED  = 3'd1,
		GST_RELEASED = 3'd2,
		GST_REPRESS  = 3'd3,
		GST_LONG     = 3'd5
	} bpec_gst_t;

	// sequencer states
	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_PRE,
		CTL_DIV,
		CTL_COMMIT
	} bpec_ctl_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic pre;
		logic commit;
	} bpec_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
	} bpec_sts_t;

endpackage

FILE: rtl/bpec_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on nothing but its parameter
module bpec_div #(
	parameter int N = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [N-1:0] divisor,
	output logic         done,
	output logic [N-1:0] quotient
);
	localparam int CW = $clog2(N + 1);

	logic         busy_q;
	logic         done_q;
	logic [CW-1:0] cnt_q;
	logic [N-1:0] rem_q;
	logic [N-1:0] quo_q;
	logic [N-1:0] dsr_q;
	logic [N:0]   trial;
	logic [N:0]   diff;
	logic         fits;

	assign trial = {rem_q, quo_q[N-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[N-1:0] : trial[N-1:0];
			quo_q <= {quo_q[N-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/bpec_dp.sv
// datapath: configuration, debounce, gesture state, memo and hold report divide
// depends on bpec_pkg and bpec_div
module bpec_dp #(
	parameter int TICK_BITS  = 16,
	parameter int COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpec_pkg::bpec_cmd_t   cmd,
	output bpec_pkg::bpec_sts_t   sts,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  pin_level,
	input  logic [7:0]            tick_count,
	output logic [2:0]            event_code,
	output logic                  event_fired,
	output logic [COUNT_BITS-1:0] click_count,
	output logic [2:0]            recent_event,
	output logic [COUNT_BITS-1:0] recent_count
);
	import bpec_pkg::*;

	localparam int TB = TICK_BITS;
	localparam int CB = COUNT_BITS;
	localparam int WB = (TB > 16) ? TB : 16;
	localparam logic [TB-1:0] TICK_MAX  = '1;
	localparam logic [CB-1:0] COUNT_MAX = '1;

	// configuration
	logic        act_q;
	logic [7:0]  deb_q;
	logic [15:0] short_q;
	logic [15:0] long_q;
	logic [15:0] rpt_q;
	logic [15:0] tmo_q;

	// input word
	logic        pin_q;
	logic [7:0]  dt_q;

	// state
	bpec_gst_t   gst_q;
	logic [TB-1:0] held_q;
	logic [7:0]  mis_q;
	logic        stab_q;
	logic [CB-1:0] rep_q;
	bpec_evt_t   cur_q;
	logic        fired_q;
	bpec_evt_t   memo_evt_q;
	logic [TB-1:0] memo_ticks_q;
	logic [CB-1:0] memo_cnt_q;

	// pre step
	logic [TB:0]   held_sum;
	logic [TB-1:0] held_pre;
	logic [7:0]    mis_inc;
	logic [7:0]    mis_pre;
	logic          stab_pre;

	// divider
	logic          div_start;
	logic          div_done;
	logic [WB-1:0] quotient;
	logic [CB-1:0] q_sat;
	logic [15:0]   period;

	// commit step
	logic          pressed;
	logic [WB-1:0] held_w;
	logic [TB:0]   memo_sum;
	logic [TB-1:0] memo_sat;
	bpec_gst_t     n_gst;
	logic [TB-1:0] n_held;
	logic [CB-1:0] n_rep;
	bpec_evt_t     n_cur;
	logic          n_fired;
	bpec_evt_t     n_memo_evt;
	logic [TB-1:0] n_memo_ticks;
	logic [CB-1:0] n_memo_cnt;

	always_comb begin
		held_sum = {1'b0, held_q} + (TB+1)'(dt_q);
		if (gst_q == GST_IDLE) begin
			held_pre = held_q;
		end else if (held_sum > {1'b0, TICK_MAX}) begin
			held_pre = TICK_MAX;
		end else begin
			held_pre = held_sum[TB-1:0];
		end

		mis_inc  = (mis_q == 8'hFF) ? mis_q : mis_q + 8'd1;
		stab_pre = stab_q;
		mis_pre  = 8'd0;
		if (pin_q != stab_q) begin
			if (mis_inc >= deb_q) begin
				stab_pre = pin_q;
			end else begin
				mis_pre = mis_inc;
			end
		end
	end

	assign sts.need_div = (gst_q == GST_LONG) && (stab_pre == act_q);
	assign sts.div_done = div_done;
	assign div_start    = cmd.pre && sts.need_div;
	assign period       = (rpt_q == 16'd0) ? 16'd1 : rpt_q;

	bpec_div #(
		.N(WB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (WB'(held_pre)),
		.divisor  (WB'(period)),
		.done     (div_done),
		.quotient (quotient)
	);

	// report count saturates before compare
	assign q_sat = (quotient > WB'(COUNT_MAX)) ? COUNT_MAX : quotient[CB-1:0];

	always_comb begin
		pressed  = (stab_q == act_q);
		held_w   = WB'(held_q);
		memo_sum = {1'b0, memo_ticks_q} + (TB+1)'(dt_q);
		memo_sat = (memo_sum > {1'b0, TICK_MAX}) ? TICK_MAX : memo_sum[TB-1:0];

		n_gst        = gst_q;
		n_held       = held_q;
		n_rep        = rep_q;
		n_cur        = cur_q;
		n_fired      = 1'b0;
		n_memo_evt   = memo_evt_q;
		n_memo_ticks = memo_ticks_q;
		n_memo_cnt   = memo_cnt_q;

		case (gst_q)
			GST_PRESSED: begin
				if (!pressed) begin
					n_cur   = EVT_UP;
					n_fired = 1'b1;
					n_held  = '0;
					n_gst   = GST_RELEASED;
				end else if (held_w > WB'(long_q)) begin
					n_cur   = EVT_LONG_START;
					n_fired = 1'b1;
					n_gst   = GST_LONG;
				end
			end
			GST_RELEASED: begin
				if (pressed) begin
					n_cur   = EVT_DOWN;
					n_fired = 1'b1;
					n_rep   = (rep_q == COUNT_MAX) ? rep_q : rep_q + 1'b1;
					n_held  = '0;
					n_gst   = GST_REPRESS;
				end else if (held_w > WB'(short_q)) begin
					n_cur        = EVT_REPEAT;
					n_fired      = 1'b1;
					n_gst        = GST_IDLE;
					n_memo_evt   = EVT_REPEAT;
					n_memo_cnt   = rep_q;
					n_memo_ticks = '0;
					n_rep        = '0;
				end
			end
			GST_REPRESS: begin
				if (!pressed) begin
					n_cur   = EVT_UP;
					n_fired = 1'b1;
					if (held_w < WB'(short_q)) begin
						n_held = '0;
						n_gst  = GST_RELEASED;
					end else begin
						n_gst = GST_IDLE;
					end
				end else if (held_w > WB'(short_q)) begin
					// second press held too long: close the click run without an event
					n_memo_evt   = EVT_REPEAT;
					n_memo_cnt   = (rep_q == '0) ? '0 : rep_q - 1'b1;
					n_memo_ticks = '0;
					n_gst        = GST_IDLE;
					n_rep        = '0;
				end
			end
			GST_LONG: begin
				if (pressed) begin
					n_cur = EVT_LONG_HOLD;
					if (q_sat > rep_q) begin
						n_rep   = q_sat;
						n_fired = 1'b1;
					end
				end else begin
					n_cur        = EVT_LONG_RELEASE;
					n_fired      = 1'b1;
					n_memo_evt   = EVT_LONG_HOLD;
					n_memo_cnt   = rep_q;
					n_memo_ticks = '0;
					n_gst        = GST_IDLE;
					n_rep        = '0;
					n_held       = '0;
				end
			end
			default: begin
				n_gst = GST_IDLE;
				if (pressed) begin
					n_cur   = EVT_DOWN;
					n_fired = 1'b1;
					n_held  = '0;
					n_rep   = CB'(1);
					n_gst   = GST_PRESSED;
				end else begin
					n_cur = EVT_NONE;
					if (memo_evt_q != EVT_NONE) begin
						n_memo_ticks = memo_sat;
						if (TB'(memo_sat) > TB'(0) &&
								WB'(memo_sat) > WB'(tmo_q)) begin
							n_memo_evt   = EVT_NONE;
							n_memo_cnt   = '0;
							n_memo_ticks = '0;
						end
					end
				end
			end
		endcase
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pin_q <= pin_level;
			dt_q  <= tick_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= RST_ACTIVE_LEVEL;
			deb_q        <= RST_DEBOUNCE;
			short_q      <= RST_SHORT;
			long_q       <= RST_LONG;
			rpt_q        <= RST_LONG_REPORT;
			tmo_q        <= RST_LAST_TIMEOUT;
			gst_q        <= GST_IDLE;
			held_q       <= '0;
			mis_q        <= '0;
			stab_q       <= ~RST_ACTIVE_LEVEL;
			rep_q        <= '0;
			cur_q        <= EVT_NONE;
			fired_q      <= 1'b0;
			memo_evt_q   <= EVT_NONE;
			memo_ticks_q <= '0;
			memo_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACTIVE_LEVEL: begin
						act_q  <= cfg_data[0];
						stab_q <= ~cfg_data[0];
						mis_q  <= '0;
					end
					REG_DEBOUNCE:     deb_q   <= cfg_data[7:0];
					REG_SHORT:        short_q <= cfg_data;
					REG_LONG:         long_q  <= cfg_data;
					REG_LONG_REPORT:  rpt_q   <= cfg_data;
					REG_LAST_TIMEOUT: tmo_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.pre) begin
				held_q <= held_pre;
				mis_q  <= mis_pre;
				stab_q <= stab_pre;
			end
			if (cmd.commit) begin
				gst_q        <= n_gst;
				held_q       <= n_held;
				rep_q        <= n_rep;
				cur_q        <= n_cur;
				fired_q      <= n_fired;
				memo_evt_q   <= n_memo_evt;
				memo_ticks_q <= n_memo_ticks;
				memo_cnt_q   <= n_memo_cnt;
			end
		end
	end

	// the state registers double as the output word
	assign event_code   = cur_q;
	assign event_fired  = fired_q;
	assign click_count  = rep_q;
	assign recent_event = memo_evt_q;
	assign recent_count = memo_cnt_q;

endmodule

FILE: rtl/bpec_ctrl.sv
// sequencer: accept, debounce step, optional divide, commit into the output word
// depends on bpec_pkg
module bpec_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bpec_pkg::bpec_cmd_t cmd,
	input  bpec_pkg::bpec_sts_t sts
);
	import bpec_pkg::*;

	bpec_ctl_t state_q;
	bpec_ctl_t state_nxt;
	logic      out_valid_q;
	logic      slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt  = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.pre    = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			CTL_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = CTL_PRE;
				end
			end
			CTL_PRE: begin
				cmd.pre   = 1'b1;
				state_nxt = sts.need_div ? CTL_DIV : CTL_COMMIT;
			end
			CTL_DIV: begin
				if (sts.div_done) begin
					state_nxt = CTL_COMMIT;
				end
			end
			CTL_COMMIT: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_nxt  = CTL_IDLE;
				end
			end
			default: begin
				state_nxt = CTL_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// a waiting output word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.commit)
		else $error("output word overwritten while stalled");

	// an accepted word is processed in the following cycle
	a_accept_pre: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == CTL_PRE))
		else $error("accepted word not processed");

	// divider completes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == CTL_DIV))
		else $error("divider finished outside divide wait");

	// a commit always follows an accepted word, never a stray one
	a_commit_origin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> ($past(state_q) == CTL_PRE || $past(state_q) == CTL_DIV ||
			$past(state_q) == CTL_COMMIT))
		else $error("commit without a word in progress");

endmodule

FILE: rtl/button_press_event_classifier_top.sv
// top level of the button press event classifier
// depends on bpec_pkg, bpec_ctrl, bpec_dp (which holds bpec_div)
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   pin_level, tick_count
//  out      source     out_valid / out_ready event_code, event_fired, click_count,
//                                            recent_event, recent_count
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// a word passes through accept, debounce step and commit into the output register
// in long hold while pressed the hold report count comes from a one-bit-per-cycle
//   divider, which adds a divide step before the commit
// asynchronous reset loads the register defaults; no clearing pass is needed
// a new word is taken while the previous result waits on out_ready; a commit
//   stalls only when the output register is still full; cfg_ready is always high
// the user must write registers only while idle; the block does not enforce it
module button_press_event_classifier_top #(
	parameter int TICK_BITS  = bpec_pkg::BPEC_TICK_BITS,
	parameter int COUNT_BITS = bpec_pkg::BPEC_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input word
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  pin_level,
	input  logic [7:0]            tick_count,
	// result word
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            event_code,
	output logic                  event_fired,
	output logic [COUNT_BITS-1:0] click_count,
	output logic [2:0]            recent_event,
	output logic [COUNT_BITS-1:0] recent_count,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data
);
	import bpec_pkg::*;

	bpec_cmd_t cmd;
	bpec_sts_t sts;
	logic      cfg_we;

	// config is always taken; register writes land in the datapath
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer: owns the in and out handshakes and the output valid flag
	bpec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: config registers, debounce, gesture state, memo, divider
	bpec_dp #(
		.TICK_BITS  (TICK_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pin_level    (pin_level),
		.tick_count   (tick_count),
		.event_code   (event_code),
		.event_fired  (event_fired),
		.click_count  (click_count),
		.recent_event (recent_event),
		.recent_count (recent_count)
	);

endmodule
